### rtl/rgc_pkg.sv
package rgc_pkg;

  localparam int MAX_WIDTH     = 2048;
  localparam int MAX_HEIGHT    = 2048;
  localparam int FRACTION_BITS = 4;

  localparam int CFG_W  = 12;
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int POS_W  = 11;
  localparam int MAG_W  = 15;
  localparam int PIX_W  = 24;
  localparam int SQ_W   = 17;
  localparam int RAD_W  = SQ_W + 2 * FRACTION_BITS;
  localparam int NQ     = (RAD_W + 1) / 2;
  localparam int REM_W  = 2 * NQ + 1;
  localparam int SUM_W  = NQ + 2;

  localparam logic [CFG_W-1:0] WIDTH_RESET = CFG_W'(640);
  localparam logic [CFG_W-1:0] WIDTH_MIN   = CFG_W'(2);
  localparam logic [CFG_W-1:0] WIDTH_MAX   = CFG_W'(MAX_WIDTH);
  localparam logic [ROW_W-1:0] ROW_LAST    = ROW_W'(MAX_HEIGHT - 1);
  localparam int               MAG_MAX     = (1 << MAG_W) - 1;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       frame_start;
  } pix_in_t;

  typedef struct packed {
    logic [MAG_W-1:0] magnitude;
    logic [POS_W-1:0] out_row;
    logic [POS_W-1:0] out_column;
  } grad_out_t;

  typedef struct packed {
    logic             valid;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] column;
  } meta_t;

  typedef logic [REM_W-1:0] rem3_t [3];
  typedef logic [NQ-1:0]    root3_t [3];

endpackage

### rtl/rgc_cell.sv
module rgc_cell #(
  parameter int BIT = 0
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  rgc_pkg::meta_t        meta_in,
  input  rgc_pkg::rem3_t        rem_in,
  input  rgc_pkg::root3_t       root_in,
  output rgc_pkg::meta_t        meta_out,
  output rgc_pkg::rem3_t        rem_out,
  output rgc_pkg::root3_t       root_out
);
  import rgc_pkg::*;

  rem3_t  rem_next;
  root3_t root_next;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic [REM_W-1:0] trial;
      trial = (REM_W'(root_in[k]) << (BIT + 1)) + (REM_W'(1) << (2 * BIT));
      if (rem_in[k] >= trial) begin
        rem_next[k]  = rem_in[k] - trial;
        root_next[k] = root_in[k] | (NQ'(1) << BIT);
      end else begin
        rem_next[k]  = rem_in[k];
        root_next[k] = root_in[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      meta_out.valid <= 1'b0;
    end else if (en) begin
      meta_out.valid  <= meta_in.valid;
      meta_out.row    <= meta_in.row;
      meta_out.column <= meta_in.column;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out  <= rem_next;
      root_out <= root_next;
    end
  end

endmodule

### rtl/roberts_cross_gradient.sv
// Roberts cross gradient magnitude over a raster stream of B,G,R pixels.
// Input channel: in_valid / in_stall / in_data, one pixel per beat in raster
// order; frame_start puts the pixel at row 0, column 0.
// Output channel: out_valid / out_stall / out_data, one beat per 2x2 window,
// tagged with the window's top-left row and column; the last row and the
// last column of a frame produce no beat.
// Config: cfg_we / cfg_data writes image_width (clamped to 2..2048); write
// only while the pipeline is empty.
// Throughput: one pixel per cycle while the pipeline is not held. Stages from
// the accepting edge to out_valid: line buffer read, tap and square stage, one
// square-root cell per result bit, then the output register.
// The whole pipeline holds while out_valid and out_stall are both high, and
// in_stall follows that condition.
// Reset clears counters, previous pixel, the held upper-left pixel and all
// valid flags, and sets image_width to 640. The line buffer is not cleared;
// row 0 fills it before any window reads it.
module roberts_cross_gradient (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [rgc_pkg::CFG_W-1:0] cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  rgc_pkg::pix_in_t          in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output rgc_pkg::grad_out_t        out_data
);
  import rgc_pkg::*;

  logic [CFG_W-1:0] image_width;
  logic [CFG_W-1:0] eff_w;
  logic             en;
  logic             accept;

  logic [CFG_W-1:0] col_cnt, col_cnt_next;
  logic [ROW_W-1:0] row_cnt, row_cnt_next;
  logic [CFG_W-1:0] col0, col1;
  logic [ROW_W-1:0] row0;
  logic [PIX_W-1:0] cur;

  logic [PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [PIX_W-1:0] top_q;
  logic [PIX_W-1:0] prev_pixel;
  logic [PIX_W-1:0] upper_left;

  logic             s1_valid;
  logic             s1_emit;
  logic [PIX_W-1:0] s1_cur, s1_bl;
  logic [POS_W-1:0] s1_row, s1_col;

  meta_t            s2_meta;
  logic [SQ_W-1:0]  s2_sq [3];

  meta_t            c_meta [NQ+1];
  rem3_t            c_rem  [NQ+1];
  root3_t           c_root [NQ+1];

  logic [SUM_W:0]   sum;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;
  assign accept   = in_valid && en;
  assign cur      = {in_data.red, in_data.green, in_data.blue};

  always_comb begin
    if (image_width < WIDTH_MIN) begin
      eff_w = WIDTH_MIN;
    end else if (image_width > WIDTH_MAX) begin
      eff_w = WIDTH_MAX;
    end else begin
      eff_w = image_width;
    end
  end

  always_comb begin
    col0 = in_data.frame_start ? '0 : col_cnt;
    row0 = in_data.frame_start ? '0 : row_cnt;
    if (col0 >= eff_w) begin
      col0 = '0;
    end
    col1 = col0 + CFG_W'(1);
    if (col1 >= eff_w) begin
      col_cnt_next = '0;
      row_cnt_next = (row0 < ROW_LAST) ? row0 + ROW_W'(1) : row0;
    end else begin
      col_cnt_next = col1;
      row_cnt_next = row0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= WIDTH_RESET;
    end else if (cfg_we) begin
      image_width <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt    <= '0;
      row_cnt    <= '0;
      prev_pixel <= '0;
      s1_valid   <= 1'b0;
    end else if (en) begin
      s1_valid <= accept;
      if (accept) begin
        col_cnt    <= col_cnt_next;
        row_cnt    <= row_cnt_next;
        prev_pixel <= cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      top_q                       <= line_mem[col0[COL_W-1:0]];
      line_mem[col0[COL_W-1:0]]   <= cur;
      s1_emit <= (row0 != '0) && (col0 != '0);
      s1_cur  <= cur;
      s1_bl   <= prev_pixel;
      s1_row  <= POS_W'(row0 - ROW_W'(1));
      s1_col  <= POS_W'(col0 - CFG_W'(1));
    end
  end

  // tap stage: gx = TL - BR, gy = TR - BL, squared per channel
  always_ff @(posedge clk) begin
    if (rst) begin
      upper_left    <= '0;
      s2_meta.valid <= 1'b0;
    end else if (en) begin
      s2_meta.valid  <= s1_valid && s1_emit;
      s2_meta.row    <= s1_row;
      s2_meta.column <= s1_col;
      if (s1_valid) begin
        upper_left <= top_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        logic signed [8:0]  gx, gy;
        logic signed [17:0] gx2, gy2;
        gx = $signed({1'b0, upper_left[8*k +: 8]}) - $signed({1'b0, s1_cur[8*k +: 8]});
        gy = $signed({1'b0, top_q[8*k +: 8]}) - $signed({1'b0, s1_bl[8*k +: 8]});
        gx2 = gx * gx;
        gy2 = gy * gy;
        s2_sq[k] <= SQ_W'(gx2[15:0]) + SQ_W'(gy2[15:0]);
      end
    end
  end

  assign c_meta[0] = s2_meta;
  for (genvar k = 0; k < 3; k++) begin : g_seed
    assign c_rem[0][k]  = REM_W'(s2_sq[k]) << (2 * FRACTION_BITS);
    assign c_root[0][k] = '0;
  end

  for (genvar i = 0; i < NQ; i++) begin : g_cell
    rgc_cell #(
      .BIT(NQ - 1 - i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .meta_in  (c_meta[i]),
      .rem_in   (c_rem[i]),
      .root_in  (c_root[i]),
      .meta_out (c_meta[i+1]),
      .rem_out  (c_rem[i+1]),
      .root_out (c_root[i+1])
    );
  end

  assign sum = (SUM_W+1)'(c_root[NQ][0]) + (SUM_W+1)'(c_root[NQ][1])
             + (SUM_W+1)'(c_root[NQ][2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= c_meta[NQ].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.magnitude  <= (sum > (SUM_W+1)'(MAG_MAX)) ? MAG_W'(MAG_MAX) : MAG_W'(sum);
      out_data.out_row    <= c_meta[NQ].row;
      out_data.out_column <= c_meta[NQ].column;
    end
  end

`ifndef SYNTHESIS
  a_frame_start: assert property (@(posedge clk) disable iff (rst)
    accept && in_data.frame_start |=> col_cnt == CFG_W'(1) && row_cnt == '0)
    else $error("frame start did not restart position");

  a_accept_s1: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted beat lost before tap stage");

  a_hold_ul: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(upper_left) && $stable(col_cnt))
    else $error("state moved while pipeline held");
`endif

endmodule
